>>> hw/rtl/pmsc_pkg.sv
// ----------------------------------------------------------------------------
// pmsc_pkg
// Types and constants shared by the power-monitor sample converter.
// ----------------------------------------------------------------------------
package pmsc_pkg;

   // Request beat: one poll attempt
   typedef struct packed {
      logic [31:0] time_ms;
      logic        read_ok;
      logic [23:0] bus_raw;
      logic [23:0] shunt_raw;
   } req_type;

   // Response beat: one converted poll
   typedef struct packed {
      logic [15:0]        bus_mv;
      logic signed [15:0] load_ma;
      logic [7:0]         load_w;
      logic               sensor_present;
      logic               measurement_valid;
      logic               power_saturated;
      logic               over_current;
      logic               over_voltage;
      logic               under_voltage;
      logic               sensor_error;
      logic [31:0]        updated_at_ms;
      logic [31:0]        failure_count;
   } rsp_type;

   // Register write beat
   localparam int CSR_IDX_W = 8;
   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [31:0]          data;
   } csr_type;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POLL_PERIOD   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHUNT_UOHM    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OC_LIMIT      = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OV_LIMIT      = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UV_LIMIT      = 8'd4;

   // Register reset values
   localparam logic [15:0] POLL_PERIOD_RST = 16'd200;
   localparam logic [19:0] SHUNT_UOHM_RST  = 20'd15000;
   localparam logic [14:0] OC_LIMIT_RST    = 15'd5000;
   localparam logic [15:0] OV_LIMIT_RST    = 16'd26000;
   localparam logic [15:0] UV_LIMIT_RST    = 16'd6000;

   // Shared divider widths: numerator up to 29 bits, divisor up to 21 bits
   localparam int DIV_NUM_W = 29;
   localparam int DIV_DEN_W = 21;

   // Power: W = floor((bus_mv * |mA| + 500000) / 1000000)
   localparam logic [31:0]          PWR_ROUND   = 32'd500000;
   localparam logic [31:0]          PWR_SAT_MIN = 32'd256000000;
   localparam logic [DIV_DEN_W-1:0] PWR_DIVISOR = 21'd1000000;

endpackage

>>> hw/rtl/pmsc_chan_if.sv
// ----------------------------------------------------------------------------
// pmsc_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface pmsc_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/pmsc_div.sv
// ----------------------------------------------------------------------------
// pmsc_div
// Restoring divider, one quotient bit per cycle, shared by current and power.
// ----------------------------------------------------------------------------
module pmsc_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pmsc_pkg::DIV_NUM_W-1:0] num,
   input  logic [pmsc_pkg::DIV_DEN_W-1:0] den,
   output logic                           done,
   output logic [pmsc_pkg::DIV_NUM_W-1:0] quot
);
   import pmsc_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_NUM_W - 1);

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   // one shift/subtract step
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
      fits  = trial >= {1'b0, den_ff};
      diff  = trial - {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;
endmodule

>>> hw/rtl/power_monitor_sample_convert_top.sv
// ----------------------------------------------------------------------------
// power_monitor_sample_convert_top
// Converts power-monitor poll beats into bus voltage, current and power.
// ----------------------------------------------------------------------------
// Usage:
//   req_if  : poll beats (timestamp, read status, raw bus and shunt words).
//   rsp_if  : one converted beat per accepted poll; polls arriving sooner
//             than the poll period after the last accepted one are dropped.
//   csr_if  : register writes, always ready; the user must see that they are
//             taken only while the block is idle; this is not enforced.
// Sequence:
//   A dropped poll is discarded while idle; a failed read goes straight to
//   the finish step. A good read runs the current divide (a load step and a
//   wait on 29 quotient bits), a shift-add power multiply, the power
//   rounding divide on the same divider (load and wait), plus the accept
//   and finish steps; when the power saturates the second divide is skipped.
//   One poll is converted at a time; req_if.ready is high only when idle.
// Reset: registers return to their defaults, the last-poll time and the
//   failure counter clear, and no response is pending.
// Stall: a finished response sits in the output register until taken; the
//   next poll is accepted meanwhile and waits at its finish step.
// ----------------------------------------------------------------------------
module power_monitor_sample_convert_top (
   input  logic        clock,
   input  logic        reset,
   pmsc_chan_if.sink   req_if,
   pmsc_chan_if.source rsp_if,
   pmsc_chan_if.sink   csr_if
);
   import pmsc_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_CUR      = 3'd1;
   localparam logic [2:0] ST_CUR_WAIT = 3'd2;
   localparam logic [2:0] ST_MUL      = 3'd3;
   localparam logic [2:0] ST_PWR      = 3'd4;
   localparam logic [2:0] ST_PWR_WAIT = 3'd5;
   localparam logic [2:0] ST_DONE     = 3'd6;

   req_type req;
   csr_type csr;

   // configuration registers
   logic [15:0] poll_period_ff;
   logic [19:0] shunt_uohm_ff;
   logic [14:0] oc_limit_ff;
   logic [15:0] ov_limit_ff;
   logic [15:0] uv_limit_ff;

   // control state
   logic [2:0]  state_ff, state_in;
   logic [31:0] last_poll_ff, last_poll_in;
   logic [31:0] failed_ff, failed_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  mul_cnt_ff, mul_cnt_in;

   // working payload
   logic [31:0]        time_ff, time_in;
   logic               err_ff, err_in;
   logic [15:0]        bus_mv_ff, bus_mv_in;
   logic               shunt_neg_ff, shunt_neg_in;
   logic [19:0]        shunt_mag_ff, shunt_mag_in;
   logic signed [15:0] load_ma_ff, load_ma_in;
   logic [15:0]        abs_ma_ff, abs_ma_in;
   logic [15:0]        mplier_ff, mplier_in;
   logic [31:0]        acc_ff, acc_in;
   logic [7:0]         load_w_ff, load_w_in;
   logic               psat_ff, psat_in;
   rsp_type            rsp_ff, rsp_in;

   // datapath helpers
   logic                 req_fire;
   logic                 csr_fire;
   logic                 rsp_free;
   logic [31:0]          elapsed;
   logic [19:0]          bus_code;
   logic [24:0]          bus_x25;
   logic [17:0]          bus_scaled;
   logic [19:0]          shunt_code;
   logic [DIV_NUM_W-1:0] cur_num;
   logic [19:0]          shunt_eff;
   logic [31:0]          pwr_sum;
   logic                 div_start;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [DIV_NUM_W-1:0] div_quot;

   assign req      = req_if.payload;
   assign csr      = csr_if.payload;
   assign req_fire = req_if.valid & req_if.ready;
   assign csr_fire = csr_if.valid & csr_if.ready;
   assign rsp_free = ~rsp_valid_ff | rsp_if.ready;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // bus: mV = floor(code * 25 / 128), saturated
   always_comb begin
      bus_code   = req.bus_raw[23:4];
      bus_x25    = {1'b0, bus_code, 4'b0} + {2'b0, bus_code, 3'b0} + {5'b0, bus_code};
      bus_scaled = bus_x25[24:7];
   end

   // shunt code magnitude and the current numerator |code| * 625
   assign shunt_code = req.shunt_raw[23:4];
   assign cur_num = {shunt_mag_ff, 9'b0} + {3'b0, shunt_mag_ff, 6'b0}
                  + {4'b0, shunt_mag_ff, 5'b0} + {5'b0, shunt_mag_ff, 4'b0}
                  + {9'b0, shunt_mag_ff};
   assign shunt_eff = (shunt_uohm_ff == '0) ? 20'd1 : shunt_uohm_ff;
   assign pwr_sum   = acc_ff + PWR_ROUND;
   assign elapsed   = req.time_ms - last_poll_ff;

   // shared divider: current in ST_CUR, power in ST_PWR
   assign div_start = (state_ff == ST_CUR) | ((state_ff == ST_PWR) & (pwr_sum < PWR_SAT_MIN));
   assign div_num   = (state_ff == ST_PWR) ? pwr_sum[DIV_NUM_W-1:0] : cur_num;
   assign div_den   = (state_ff == ST_PWR) ? PWR_DIVISOR : {shunt_eff, 1'b0};

   pmsc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      last_poll_in = last_poll_ff;
      failed_in    = failed_ff;
      mul_cnt_in   = mul_cnt_ff;
      time_in      = time_ff;
      err_in       = err_ff;
      bus_mv_in    = bus_mv_ff;
      shunt_neg_in = shunt_neg_ff;
      shunt_mag_in = shunt_mag_ff;
      load_ma_in   = load_ma_ff;
      abs_ma_in    = abs_ma_ff;
      mplier_in    = mplier_ff;
      acc_in       = acc_ff;
      load_w_in    = load_w_ff;
      psat_in      = psat_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_if.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && elapsed >= {16'b0, poll_period_ff}) begin
               last_poll_in = req.time_ms;
               time_in      = req.time_ms;
               err_in       = ~req.read_ok;
               bus_mv_in    = (|bus_scaled[17:16]) ? 16'hFFFF : bus_scaled[15:0];
               shunt_neg_in = shunt_code[19];
               shunt_mag_in = shunt_code[19] ? (20'd0 - shunt_code) : shunt_code;
               load_w_in    = '0;
               psat_in      = 1'b0;
               if (req.read_ok) begin
                  state_in = ST_CUR;
               end else begin
                  failed_in = failed_ff + 32'd1;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_CUR: begin
            state_in = ST_CUR_WAIT;
         end
         ST_CUR_WAIT: begin
            if (div_done) begin
               // saturate the quotient to the signed 16-bit range
               if (shunt_neg_ff) begin
                  abs_ma_in  = (div_quot > 29'd32768) ? 16'h8000 : div_quot[15:0];
                  load_ma_in = 16'sd0 - $signed(abs_ma_in);
               end else begin
                  abs_ma_in  = (div_quot > 29'd32767) ? 16'h7FFF : div_quot[15:0];
                  load_ma_in = $signed(abs_ma_in);
               end
               mplier_in  = abs_ma_in;
               acc_in     = '0;
               mul_cnt_in = '0;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            // shift-add, multiplier MSB first
            acc_in     = {acc_ff[30:0], 1'b0} + (mplier_ff[15] ? {16'b0, bus_mv_ff} : 32'd0);
            mplier_in  = {mplier_ff[14:0], 1'b0};
            mul_cnt_in = mul_cnt_ff + 1'b1;
            if (mul_cnt_ff == 4'hF) begin
               state_in = ST_PWR;
            end
         end
         ST_PWR: begin
            if (pwr_sum >= PWR_SAT_MIN) begin
               load_w_in = 8'hFF;
               psat_in   = 1'b1;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_PWR_WAIT;
            end
         end
         ST_PWR_WAIT: begin
            if (div_done) begin
               load_w_in = div_quot[7:0];
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_in.bus_mv            = err_ff ? 16'd0 : bus_mv_ff;
               rsp_in.load_ma           = err_ff ? 16'sd0 : load_ma_ff;
               rsp_in.load_w            = err_ff ? 8'd0 : load_w_ff;
               rsp_in.sensor_present    = ~err_ff;
               rsp_in.measurement_valid = ~err_ff;
               rsp_in.power_saturated   = ~err_ff & psat_ff;
               rsp_in.over_current      = ~err_ff & (abs_ma_ff >= {1'b0, oc_limit_ff});
               rsp_in.over_voltage      = ~err_ff & (bus_mv_ff > ov_limit_ff);
               rsp_in.under_voltage     = ~err_ff & (bus_mv_ff != '0)
                                          & (bus_mv_ff < uv_limit_ff);
               rsp_in.sensor_error      = err_ff;
               rsp_in.updated_at_ms     = time_ff;
               rsp_in.failure_count     = failed_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // payload registers
   always_ff @(posedge clock) begin
      mul_cnt_ff   <= mul_cnt_in;
      time_ff      <= time_in;
      err_ff       <= err_in;
      bus_mv_ff    <= bus_mv_in;
      shunt_neg_ff <= shunt_neg_in;
      shunt_mag_ff <= shunt_mag_in;
      load_ma_ff   <= load_ma_in;
      abs_ma_ff    <= abs_ma_in;
      mplier_ff    <= mplier_in;
      acc_ff       <= acc_in;
      load_w_ff    <= load_w_in;
      psat_ff      <= psat_in;
      rsp_ff       <= rsp_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_poll_ff <= '0;
         failed_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_poll_ff <= last_poll_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_period_ff <= POLL_PERIOD_RST;
         shunt_uohm_ff  <= SHUNT_UOHM_RST;
         oc_limit_ff    <= OC_LIMIT_RST;
         ov_limit_ff    <= OV_LIMIT_RST;
         uv_limit_ff    <= UV_LIMIT_RST;
      end else if (csr_fire) begin
         case (csr.index)
            CSR_POLL_PERIOD: poll_period_ff <= csr.data[15:0];
            CSR_SHUNT_UOHM:  shunt_uohm_ff  <= csr.data[19:0];
            CSR_OC_LIMIT:    oc_limit_ff    <= csr.data[14:0];
            CSR_OV_LIMIT:    ov_limit_ff    <= csr.data[15:0];
            CSR_UV_LIMIT:    uv_limit_ff    <= csr.data[15:0];
            default: begin
            end
         endcase
      end
   end
endmodule
